// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define WSS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define WSS_ASSERT(label, clk, rst_n, prop)
`define WSS_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/wss_pkg.sv =====
// Types and constants for the weight stage sequencer.
package wss_pkg;

    localparam int MAX_STAGES_DEF = 6;
    localparam int SLOT_REGS      = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int STAGE_WORD_W   = 33;
    localparam int MET_MARGIN     = 5;
    localparam int MS_PER_S       = 1000;
    localparam int HOLD_MS_W      = 26;

    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for any 32-bit x
    localparam logic [28:0] DIV_MAGIC = 29'h10624DD3;
    localparam int          DIV_SHIFT = 38;
    localparam int          PROD_W    = 61;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STAGE_0      = 3'd0,
        CFG_STAGE_1      = 3'd1,
        CFG_STAGE_2      = 3'd2,
        CFG_STAGE_3      = 3'd3,
        CFG_STAGE_4      = 3'd4,
        CFG_STAGE_5      = 3'd5,
        CFG_SLOTS_IN_USE = 3'd6,
        CFG_TOTAL_WATER  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [19:0] weight;
        logic [31:0]        clock_ms;
        logic               running;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  stages_enabled;
        logic        multi_stage;
        logic [2:0]  active_position;
        logic        brew_done;
        logic [15:0] stage_start_weight;
        logic [15:0] stage_target_weight;
        logic [15:0] stage_hold;
        logic [15:0] hold_left;
        logic        hold_active;
    } out_item_t;

endpackage

// ===== rtl/core/weight_stage_sequencer_unit.sv =====
// Weight stage sequencer: recipe registers, stage state and the result pipeline.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | in        | in_valid / in_stall   | in_data   (wss_pkg::in_item_t)
//  out      | out       | out_valid / out_stall | out_data  (wss_pkg::out_item_t)
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless out stalls; a result passes the input register,
// stage update, reciprocal multiply for the hold seconds and output register.
// Stage state (position, hold, done) is updated per sample, so samples follow back to back.
// Reset clears the recipe registers, stage state and all pipeline valids.
// An out stall holds stages up to the first gap; in_stall rises only when all are full.
module weight_stage_sequencer_unit #(
    parameter int MAX_STAGES = wss_pkg::MAX_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  wss_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output wss_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wss_pkg::STAGE_WORD_W-1:0] cfg_data
);
    import wss_pkg::*;

    // recipe registers
    logic [MAX_STAGES-1:0] en_reg;
    logic [15:0]           target_reg  [MAX_STAGES];
    logic [15:0]           hold_reg    [MAX_STAGES];
    logic [HOLD_MS_W-1:0]  hold_ms_reg [MAX_STAGES];
    logic [2:0]            slots_reg;
    logic [15:0]           water_reg;

    // stage state
    logic [2:0]  ap_reg, ap_next;
    logic        done_reg, done_next;
    logic        in_hold_reg, in_hold_next;
    logic [31:0] hb_reg, hb_next;

    // pipeline
    logic        v0_reg, v1_reg, v2_reg, v3_reg;
    logic        en0, en1, en2, en3;
    in_item_t    in_reg;
    out_item_t   s1_reg, s1_next, s2_reg, out_reg, out_next;
    logic [31:0] el_reg, el_next;
    logic        rf1_reg, rf1_next, rf2_reg;
    logic [PROD_W-1:0] prod_reg;

    // enabled-stage map
    logic [MAX_STAGES-1:0] on;
    logic [2:0]            pos_of [MAX_STAGES];
    logic [2:0]            count;

    // selection at the pre-update position
    logic [2:0]           pos_c;
    logic [15:0]          cur_target, cur_hold;
    logic [HOLD_MS_W-1:0] cur_hold_ms;

    // update working signals
    logic                 met, start, ih, hold_over;
    logic [31:0]          hb_w, el_w;
    logic signed [20:0]   w_ext, thr;

    // selection at the post-update position
    logic [15:0] new_target, new_hold, prev_target;

    logic [22:0] secs;

    logic        pos_bad;

    assign cfg_ready = 1'b1;

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign in_stall  = !en0;
    assign out_valid = v3_reg;
    assign out_data  = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= '0;
            slots_reg <= '0;
            water_reg <= '0;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                target_reg[i]  <= '0;
                hold_reg[i]    <= '0;
                hold_ms_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SLOTS_IN_USE: slots_reg <= cfg_data[2:0];
                CFG_TOTAL_WATER:  water_reg <= cfg_data[15:0];
                default:
                begin
                    for (int i = 0; i < MAX_STAGES; i++)
                    begin
                        if (32'(cfg_index) == i)
                        begin
                            en_reg[i]      <= cfg_data[0];
                            target_reg[i]  <= cfg_data[16:1];
                            hold_reg[i]    <= cfg_data[32:17];
                            hold_ms_reg[i] <= HOLD_MS_W'(cfg_data[32:17]) *
                                              HOLD_MS_W'(MS_PER_S);
                        end
                    end
                end
            endcase
        end
    end

    // which slots count, and each one's place among the enabled stages
    always_comb
    begin
        logic [2:0] acc;
        acc = '0;
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            on[i]     = en_reg[i] && (target_reg[i] != '0) && (i < 32'(slots_reg));
            pos_of[i] = acc;
            acc       = acc + 3'(on[i]);
        end
        count = acc;
    end

    always_comb
    begin
        if (count == '0)
            pos_c = '0;
        else if (ap_reg >= count)
            pos_c = count - 3'd1;
        else
            pos_c = ap_reg;
        cur_target  = '0;
        cur_hold    = '0;
        cur_hold_ms = '0;
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            if (on[i] && pos_of[i] == pos_c)
            begin
                cur_target  = cur_target  | target_reg[i];
                cur_hold    = cur_hold    | hold_reg[i];
                cur_hold_ms = cur_hold_ms | hold_ms_reg[i];
            end
        end
    end

    // stage state update for the sample in the input register
    always_comb
    begin
        w_ext     = {in_reg.weight[19], in_reg.weight};
        thr       = $signed({5'b0, cur_target}) - 21'(MET_MARGIN);
        met       = w_ext >= thr;
        start     = met && (cur_hold != '0) && !in_hold_reg;
        ih        = in_hold_reg || start;
        hb_w      = start ? in_reg.clock_ms : hb_reg;
        el_w      = (in_reg.clock_ms >= hb_w) ? in_reg.clock_ms - hb_w : '0;
        hold_over = ih ? (el_w >= 32'(cur_hold_ms)) : (cur_hold == '0);

        ap_next      = ap_reg;
        done_next    = done_reg;
        in_hold_next = in_hold_reg;
        hb_next      = hb_reg;
        rf1_next     = 1'b0;
        el_next      = el_w;

        if (count == '0 || (!in_reg.running && in_reg.clock_ms == '0))
        begin
            ap_next      = '0;
            done_next    = 1'b0;
            in_hold_next = 1'b0;
            hb_next      = '0;
        end
        else
        begin
            ap_next = pos_c;
            if (!in_reg.running || done_reg)
            begin
                in_hold_next = 1'b0;
            end
            else if (met && hold_over)
            begin
                in_hold_next = 1'b0;
                if ({1'b0, pos_c} + 4'd1 < {1'b0, count})
                begin
                    ap_next = pos_c + 3'd1;
                    hb_next = '0;
                end
                else
                begin
                    done_next = 1'b1;
                    hb_next   = hb_w;
                end
            end
            else
            begin
                in_hold_next = ih;
                hb_next      = hb_w;
                rf1_next     = ih && !hold_over;      // hold running with time left
            end
        end
    end

    // result fields at the position left by the update
    always_comb
    begin
        new_target  = '0;
        new_hold    = '0;
        prev_target = '0;
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            if (on[i] && pos_of[i] == ap_next)
            begin
                new_target = new_target | target_reg[i];
                new_hold   = new_hold   | hold_reg[i];
            end
            if (on[i] && ap_next != '0 && pos_of[i] == ap_next - 3'd1)
                prev_target = prev_target | target_reg[i];
        end

        s1_next                 = '0;
        s1_next.stages_enabled  = count;
        s1_next.multi_stage     = count > 3'd1;
        s1_next.active_position = ap_next;
        s1_next.brew_done       = done_next;
        if (count == '0)
        begin
            s1_next.stage_target_weight = water_reg;
        end
        else
        begin
            s1_next.stage_start_weight  = prev_target;
            s1_next.stage_target_weight = new_target;
            s1_next.stage_hold          = new_hold;
            s1_next.hold_active         = rf1_next;
        end
    end

    // hold seconds left from the multiply result
    always_comb
    begin
        secs     = prod_reg[PROD_W-1:DIV_SHIFT];
        out_next = s2_reg;
        out_next.hold_left = rf2_reg ? s2_reg.stage_hold - secs[15:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ap_reg      <= '0;
            done_reg    <= 1'b0;
            in_hold_reg <= 1'b0;
            hb_reg      <= '0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end
        else
        begin
            if (en0)
                v0_reg <= in_valid;
            if (en1)
            begin
                v1_reg <= v0_reg;
                if (v0_reg)
                begin
                    ap_reg      <= ap_next;
                    done_reg    <= done_next;
                    in_hold_reg <= in_hold_next;
                    hb_reg      <= hb_next;
                end
            end
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
            in_reg <= in_data;
        if (en1)
        begin
            s1_reg  <= s1_next;
            el_reg  <= el_next;
            rf1_reg <= rf1_next;
        end
        if (en2)
        begin
            s2_reg   <= s1_reg;
            rf2_reg  <= rf1_reg;
            prod_reg <= PROD_W'(el_reg) * PROD_W'(DIV_MAGIC);
        end
        if (en3)
            out_reg <= out_next;
    end

    assign pos_bad = (out_data.stages_enabled != '0) &&
                     (out_data.active_position >= out_data.stages_enabled);

`include "assert_macros.svh"

    `WSS_NEVER(a_pos_in_range, clk, rst_n, out_valid && pos_bad)
    `WSS_ASSERT(a_hold_left, clk, rst_n, out_valid && out_data.hold_active |-> |out_data.hold_left)
    `WSS_NEVER(a_hold_after_done, clk, rst_n, in_hold_reg && done_reg)
    `WSS_ASSERT(a_out_held, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

endmodule
